/* hw/rtl/cpt_pkg.sv */
// Shared types and constants for the convex polygon point test.
package cpt_pkg;

   localparam int COORD_W = 24;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;

   localparam logic OP_APPEND   = 1'b0;
   localparam logic OP_QUERY    = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic                       op;
      logic signed [COORD_W-1:0]  x_coord;
      logic signed [COORD_W-1:0]  y_coord;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic status;
   } rsp_type;

   // Stored vertex: y in the upper half, x in the lower half.
   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } vertex_type;

   // Tag that travels with each vertex read during a query walk.
   typedef struct packed {
      logic vld;
      logic first;   // read of vertex 0, only primes the previous vertex
      logic edge0;   // completes the first edge
      logic last;    // completes the closing edge
   } edge_tag_type;

   typedef struct packed {
      logic done;
      logic enclosed;
   } verdict_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_REPLY
   } ctl_state_type;

endpackage

/* hw/rtl/cpt_vertex_ram.sv */
// Vertex store: one write port, one read port, registered read data.
module cpt_vertex_ram
   import cpt_pkg::*;
#(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  vertex_type        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output vertex_type        rd_data
);

   vertex_type mem [DEPTH];
   vertex_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/cpt_cross_pipe.sv */
// Edge pipeline: differences, cross products, sign check and running verdict.
module cpt_cross_pipe
   import cpt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  edge_tag_type tag_in,
   input  vertex_type   rd_vertex,
   input  vertex_type   point,
   output verdict_type  verdict
);

   // stage 1: previous vertex and differences
   vertex_type               prev_ff, prev_in;
   logic signed [DIFF_W-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [DIFF_W-1:0] ax_in, ay_in, bx_in, by_in;
   logic                     s2_vld_ff, s2_vld_in;
   logic                     s2_edge0_ff, s2_last_ff;

   // stage 2: products
   logic signed [PROD_W-1:0] p1_ff, p2_ff, p1_in, p2_in;
   logic                     s3_vld_ff, s3_edge0_ff, s3_last_ff;

   // stage 3: sign and running verdict
   logic cur_pos, cur_zero, fail, inside_now;
   logic prev_pos_ff, prev_zero_ff, inside_ff;

   always_comb begin
      prev_in   = tag_in.vld ? rd_vertex : prev_ff;
      s2_vld_in = tag_in.vld & ~tag_in.first;
      ax_in = {point.x[COORD_W-1], point.x} - {prev_ff.x[COORD_W-1], prev_ff.x};
      ay_in = {point.y[COORD_W-1], point.y} - {prev_ff.y[COORD_W-1], prev_ff.y};
      bx_in = {rd_vertex.x[COORD_W-1], rd_vertex.x} - {prev_ff.x[COORD_W-1], prev_ff.x};
      by_in = {rd_vertex.y[COORD_W-1], rd_vertex.y} - {prev_ff.y[COORD_W-1], prev_ff.y};
      p1_in = ax_ff * by_ff;
      p2_in = ay_ff * bx_ff;
   end

   // cross = p1 - p2; only its sign matters
   always_comb begin
      cur_pos    = p1_ff > p2_ff;
      cur_zero   = p1_ff == p2_ff;
      fail       = cur_zero | prev_zero_ff | (cur_pos != prev_pos_ff);
      inside_now = s3_edge0_ff | (inside_ff & ~fail);
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      bx_ff   <= bx_in;
      by_ff   <= by_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      s2_edge0_ff <= tag_in.edge0;
      s2_last_ff  <= tag_in.last;
      s3_edge0_ff <= s2_edge0_ff;
      s3_last_ff  <= s2_last_ff;
      if (s3_vld_ff) begin
         prev_pos_ff  <= cur_pos;
         prev_zero_ff <= cur_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         inside_ff <= 1'b1;
      end else begin
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s2_vld_ff;
         if (s3_vld_ff) begin
            inside_ff <= inside_now;
         end
      end
   end

   assign verdict.done     = s3_vld_ff & s3_last_ff;
   assign verdict.enclosed = inside_now;

endmodule

/* hw/rtl/convex_polygon_point_test.sv */
// Top level: vertex list with append and point-in-convex-polygon query.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-------------------------------
//  req_     | in  | req_valid / req_ready  | req_type (op, x_coord, y_coord)
//  rsp_     | out | rsp_valid / rsp_ready  | rsp_type (inside_res, status)
//
// An append, or a query over fewer than two vertices, goes from idle
// straight to the reply state, which loads the response register. A
// query over n >= 2 vertices walks the store instead: n + 1 reads from
// the single read port of the vertex RAM (vertex 0 is read again to close
// the polygon), three pipeline stages, then the reply. Reset is
// synchronous and clears the vertex count; no clearing pass is needed. A
// transaction is accepted only in idle; the reply waits while the output
// register still holds an unaccepted response, and one pending response
// may wait there while the next transaction is taken.
module convex_polygon_point_test
   import cpt_pkg::*;
#(
   parameter int MAX_VERTICES = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int ADDR_W = $clog2(MAX_VERTICES);

   ctl_state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;   // stored vertices
   logic [CNT_W-1:0] k_ff, k_in;           // walk read index; reads cover 0..count
   vertex_type       point_ff, point_in;
   rsp_type          pend_ff, pend_in;     // finished result awaiting the output register
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   edge_tag_type     tag_ff, tag_in;       // aligned with RAM read data

   logic              req_acc, store_full, rsp_load;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   vertex_type        wr_data, rd_data;
   verdict_type       verdict;

   assign req_acc    = req_valid & req_ready;
   assign store_full = count_ff >= CNT_W'(MAX_VERTICES);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_payload.op == OP_QUERY && count_ff >= CNT_W'(2)) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_WALK: begin
            if (k_ff == count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (verdict.done) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      req_ready = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rsp_load  = 1'b0;
      wr_addr   = count_ff[ADDR_W-1:0];
      wr_data   = '{y: req_payload.y_coord, x: req_payload.x_coord};
      rd_addr   = (k_ff == count_ff) ? '0 : k_ff[ADDR_W-1:0];
      count_in  = count_ff;
      k_in      = k_ff;
      point_in  = point_ff;
      pend_in   = pend_ff;
      tag_in    = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            k_in      = '0;
            point_in  = '{y: req_payload.y_coord, x: req_payload.x_coord};
            if (req_acc) begin
               if (req_payload.op == OP_APPEND) begin
                  pend_in = '{inside_res: 1'b0, status: store_full ? STATUS_FULL : STATUS_OK};
                  if (!store_full) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  // query: inside by definition under two vertices, else the walk result replaces it
                  pend_in = '{inside_res: 1'b1, status: STATUS_OK};
               end
            end
         end
         ST_WALK: begin
            rd_en        = 1'b1;
            tag_in.vld   = 1'b1;
            tag_in.first = k_ff == '0;
            tag_in.edge0 = k_ff == CNT_W'(1);
            tag_in.last  = k_ff == count_ff;
            k_in         = k_ff + CNT_W'(1);
         end
         ST_DRAIN: begin
            if (verdict.done) begin
               pend_in = '{inside_res: verdict.enclosed, status: STATUS_OK};
            end
         end
         ST_REPLY: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: ;
      endcase
      rsp_in       = rsp_load ? pend_ff : rsp_ff;
      rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         tag_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         tag_ff       <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      point_ff <= point_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   cpt_vertex_ram #(
      .DEPTH  (MAX_VERTICES),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cpt_cross_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .tag_in    (tag_ff),
      .rd_vertex (rd_data),
      .point     (point_ff),
      .verdict   (verdict)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VERTICES))
      else $error("vertex count above store depth");

   // a walk result only shows up while waiting for it
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      verdict.done |-> state_ff == ST_DRAIN)
      else $error("walk verdict outside drain");

   // an accepted append into a non-full store grows the list by one
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_payload.op == OP_APPEND && !store_full)
         |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not grow the list");

   // walk reads stay inside the written part of the store
   a_read_written: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> ({1'b0, rd_addr} < (ADDR_W + 1)'(count_ff)))
      else $error("read beyond stored vertices");

endmodule

/* tb/sv/tb_convex_polygon_point_test.sv */
// Self-checking testbench for the convex polygon point test block.
module tb_convex_polygon_point_test;
   import cpt_pkg::*;

   localparam int     VERTEX_CAP   = 64;
   localparam int     CLOCK_PERIOD = 12;
   localparam real    PI           = 3.14159265358979;
   localparam longint COORD_MAX    = (longint'(1) <<< (COORD_W - 1)) - 1;
   localparam longint COORD_MIN    = -(longint'(1) <<< (COORD_W - 1));
   // Long receiver hold that backs the block up into its input channel.
   localparam int     BACKLOG_HOLD = 400;
   // Drain margin at the end, past the longest query walk over a full store.
   localparam int     DRAIN_CYCLES = VERTEX_CAP + 16;
   localparam int     PRINT_CAP    = 40;

   // ------------------------------------------------------------------
   // Scoreboard: mirrors the vertex list, predicts one response per
   // accepted request transaction and compares responses in order.
   // ------------------------------------------------------------------
   class polygon_scoreboard;
      longint  corner_x [VERTEX_CAP];
      longint  corner_y [VERTEX_CAP];
      int      corners;
      rsp_type awaited [$];
      int      mismatches;
      int      checked;
      int      queries;
      int      inside_hits;
      int      stored;
      int      dropped;

      // Edge walk with wrap: the z of (P - Vi) x (Vj - Vi) must keep one
      // nonzero sign on every edge. Zero on any edge means outside.
      function bit encloses(longint px, longint py);
         int     nxt;
         int     cur;
         int     prev;
         longint cross_z;
         prev = 0;
         for (int i = 0; i < corners; i++) begin
            nxt     = (i + 1 == corners) ? 0 : i + 1;
            cross_z = (px - corner_x[i]) * (corner_y[nxt] - corner_y[i])
                    - (py - corner_y[i]) * (corner_x[nxt] - corner_x[i]);
            cur     = (cross_z > 0) ? 1 : ((cross_z < 0) ? -1 : 0);
            if (i > 0 && (cur == 0 || prev == 0 || cur != prev)) return 1'b0;
            prev = cur;
         end
         // Empty or single-vertex list falls through as inside.
         return 1'b1;
      endfunction

      function void note_request(req_type item);
         rsp_type want;
         longint  px;
         longint  py;
         px              = longint'($signed(item.x_coord));
         py              = longint'($signed(item.y_coord));
         want.inside_res = 1'b0;
         want.status     = STATUS_OK;
         if (item.op == OP_APPEND) begin
            if (corners < VERTEX_CAP) begin
               corner_x[corners] = px;
               corner_y[corners] = py;
               corners++;
               stored++;
            end else begin
               want.status = STATUS_FULL;
               dropped++;
            end
         end else begin
            want.inside_res = encloses(px, py);
            queries++;
            if (want.inside_res) inside_hits++;
         end
         awaited = {awaited, want};
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         checked++;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                      checked));
            return;
         end
         want = awaited.pop_front();
         if (got.inside_res !== want.inside_res)
            report_mismatch($sformatf("response %0d inside_res: expected %b, got %b",
                                      checked, want.inside_res, got.inside_res));
         if (got.status !== want.status)
            report_mismatch($sformatf("response %0d status: expected %b, got %b",
                                      checked, want.status, got.status));
      endtask
   endclass

   // ------------------------------------------------------------------
   // DUT and its signals; every input starts at a known value.
   // ------------------------------------------------------------------
   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   polygon_scoreboard sb = new();

   convex_polygon_point_test #(.MAX_VERTICES(VERTEX_CAP)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // Stimulus state. hull_* is a convex polygon in counterclockwise order,
   // so every prefix of three or more is itself convex. list_* tracks what
   // actually went into the store, for picking query points.
   // ------------------------------------------------------------------
   longint hull_x [VERTEX_CAP];
   longint hull_y [VERTEX_CAP];
   longint list_x [VERTEX_CAP];
   longint list_y [VERTEX_CAP];
   int     list_n;
   int     items_sent;

   function automatic longint rand_coord();
      return longint'($signed(COORD_W'($urandom)));
   endfunction

   function automatic longint clamp_coord(longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   // Sender idle: mostly back to back, some short gaps, a few long ones.
   // A window of items runs with no gaps at all.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (items_sent >= 200 && items_sent < 260) return 0;
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Query mix once a polygon exists: interior points from weighted vertex
   // triples, exact vertices, edge midpoints, near-vertex nudges, the
   // corners of the coordinate range and plain full-range noise.
   function automatic void pick_query(output longint qx, output longint qy);
      int kind;
      int a;
      int b;
      int c;
      int wa;
      int wb;
      int wc;
      kind = $urandom_range(0, 99);
      qx   = rand_coord();
      qy   = rand_coord();
      if (list_n < 3 || kind < 25) return;
      a = $urandom_range(0, list_n - 1);
      b = (a + 1) % list_n;
      if (kind < 65) begin
         b = (a + 1 + $urandom_range(0, list_n - 2)) % list_n;
         do c = $urandom_range(0, list_n - 1); while (c == a || c == b);
         wa = $urandom_range(1, 7);
         wb = $urandom_range(1, 7);
         wc = $urandom_range(1, 7);
         qx = (wa * list_x[a] + wb * list_x[b] + wc * list_x[c]) / (wa + wb + wc);
         qy = (wa * list_y[a] + wb * list_y[b] + wc * list_y[c]) / (wa + wb + wc);
      end else if (kind < 75) begin
         qx = list_x[a];
         qy = list_y[a];
      end else if (kind < 85) begin
         qx = (list_x[a] + list_x[b]) >>> 1;
         qy = (list_y[a] + list_y[b]) >>> 1;
      end else if (kind < 95) begin
         wa = $urandom_range(0, 6);
         wb = $urandom_range(0, 6);
         qx = clamp_coord(list_x[a] + wa - 3);
         qy = clamp_coord(list_y[a] + wb - 3);
      end else begin
         qx = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         qy = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      end
   endfunction

   // One request transaction: optional idle gap, then valid held with a
   // stable payload until the handshake completes. Valid is only lowered
   // when a gap follows, never dropped and re-raised in one time step.
   task automatic drive_req(req_type item, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(item);
      items_sent++;
   endtask

   task automatic send_vertex(longint x, longint y, int gap);
      req_type item;
      item.op      = OP_APPEND;
      item.x_coord = COORD_W'(x);
      item.y_coord = COORD_W'(y);
      if (list_n < VERTEX_CAP) begin
         list_x[list_n] = x;
         list_y[list_n] = y;
         list_n++;
      end
      drive_req(item, gap);
   endtask

   task automatic send_query(longint x, longint y, int gap);
      req_type item;
      item.op      = OP_QUERY;
      item.x_coord = COORD_W'(x);
      item.y_coord = COORD_W'(y);
      drive_req(item, gap);
   endtask

   // ------------------------------------------------------------------
   // Response side: checks every accepted response transaction and drives
   // rsp_ready. Random stalls, recurring calm windows in which no new stall
   // starts, and one long hold once 150 responses are in.
   // ------------------------------------------------------------------
   int   cycle_count;
   int   hold_left;
   int   roll;
   bit   backlog_done;
   logic ready_next;

   always @(posedge clock) begin
      cycle_count++;
      if (rsp_valid && rsp_ready) sb.check_response(rsp_payload);
      if (reset) begin
         ready_next = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         ready_next = 1'b0;
      end else if (!backlog_done && sb.checked >= 150) begin
         // Sender keeps offering during this hold, so the response
         // register fills and req_ready has to drop.
         backlog_done = 1'b1;
         hold_left    = BACKLOG_HOLD - 1;
         ready_next   = 1'b0;
      end else if ((cycle_count / 1500) % 4 == 2) begin
         ready_next = 1'b1;
      end else begin
         roll       = $urandom_range(0, 99);
         ready_next = 1'b1;
         if (roll >= 70) begin
            ready_next = 1'b0;
            hold_left  = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(14, 59);
         end
      end
      rsp_ready <= ready_next;
   end

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      real    angle;
      real    radius;
      int     plan;
      longint qx;
      longint qy;
      longint cx;
      longint cy;

      // Vertices on a circle spanning the full coordinate range, kept even
      // so edge midpoints land exactly on the edge. The four axis points
      // are then pinned to the extremes of the field, which leaves COORD_MAX odd.
      radius = real'(COORD_MAX);
      for (int k = 0; k < VERTEX_CAP; k++) begin
         angle     = 2.0 * PI * k / VERTEX_CAP;
         hull_x[k] = 2 * longint'(radius * $cos(angle) / 2.0);
         hull_y[k] = 2 * longint'(radius * $sin(angle) / 2.0);
      end
      hull_x[0]                  = COORD_MAX;
      hull_y[0]                  = 0;
      hull_x[VERTEX_CAP / 4]     = 0;
      hull_y[VERTEX_CAP / 4]     = COORD_MAX;
      hull_x[VERTEX_CAP / 2]     = COORD_MIN;
      hull_y[VERTEX_CAP / 2]     = 0;
      hull_x[3 * VERTEX_CAP / 4] = 0;
      hull_y[3 * VERTEX_CAP / 4] = COORD_MIN;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // Empty list: anything reads as inside, range extremes included.
      send_query(0, 0, 0);
      send_query(COORD_MIN, COORD_MAX, 1);
      // Single vertex: still inside, even at the vertex itself.
      send_vertex(hull_x[0], hull_y[0], 0);
      send_query(hull_x[0], hull_y[0], 0);
      send_query(COORD_MAX, COORD_MIN, 2);
      // Two vertices: the closing edge reverses the sign, never inside.
      send_vertex(hull_x[1], hull_y[1], 0);
      send_query((hull_x[0] + hull_x[1]) / 2, (hull_y[0] + hull_y[1]) / 2, 0);
      send_query(0, 0, 0);
      // Triangle.
      send_vertex(hull_x[2], hull_y[2], 3);
      cx = (hull_x[0] + hull_x[1] + hull_x[2]) / 3;
      cy = (hull_y[0] + hull_y[1] + hull_y[2]) / 3;
      send_query(cx, cy, 0);
      send_query(-cx, -cy, 0);
      send_query(hull_x[1], hull_y[1], 0);
      // Exactly on an edge: outside.
      send_query((hull_x[1] + hull_x[2]) / 2, (hull_y[1] + hull_y[2]) / 2, 0);
      // On the line of an edge, beyond its end.
      send_query(clamp_coord(2 * hull_x[2] - hull_x[1]),
                 clamp_coord(2 * hull_y[2] - hull_y[1]), 1);
      send_query(COORD_MIN, COORD_MIN, 0);
      send_query(COORD_MAX, COORD_MAX, 0);
      send_query(cx + 1, cy - 1, 0);

      // --- random: grow the convex polygon, querying between appends ---
      for (int v = 3; v < VERTEX_CAP - 4; v++) begin
         plan = $urandom_range(2, 11);
         repeat (plan) begin
            pick_query(qx, qy);
            send_query(qx, qy, pick_gap());
         end
         send_vertex(hull_x[v], hull_y[v], pick_gap());
      end

      // --- broken tail: repeated vertex, noise vertices, full store ---
      send_vertex(list_x[list_n - 1], list_y[list_n - 1], pick_gap());
      repeat (6) begin
         pick_query(qx, qy);
         send_query(qx, qy, pick_gap());
      end
      while (list_n < VERTEX_CAP) begin
         send_vertex(rand_coord(), rand_coord(), pick_gap());
         pick_query(qx, qy);
         send_query(qx, qy, pick_gap());
      end
      // Appends from here on are refused.
      repeat (12) begin
         send_vertex(rand_coord(), rand_coord(), pick_gap());
         pick_query(qx, qy);
         send_query(qx, qy, pick_gap());
      end
      req_valid <= 1'b0;

      // Drain: wait for every outstanding response, then watch for strays.
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d transactions: %0d queries (%0d predicted inside), %0d vertices stored,",
               items_sent, sb.queries, sb.inside_hits, sb.stored);
      $display("%0d appends refused on a full list, %0d responses checked, %0d mismatches.",
               sb.dropped, sb.checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #(CLOCK_PERIOD * 1000000);
      $display("[%0t] watchdog expired, %0d responses outstanding", $time,
               sb.awaited.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
